// ----- hw/rtl/sha256_stream_hasher_macros.svh -----
// Assertion helpers used by the stream hasher RTL.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/sha256_pkg.sv -----
package sha256_pkg;

    localparam int unsigned BufDepth   = 64;
    localparam int unsigned BufAw      = 6;
    localparam int unsigned SchedDepth = 16;
    localparam int unsigned RoundCount = 64;

    typedef logic [31:0] t_word;

    // Control group from the sequencer to the round engine.
    typedef struct packed {
        logic       start;   // load working variables from the hash words
        logic       round;   // perform one round
        logic [5:0] idx;     // round number
        logic       finish;  // fold working variables into the hash words
        logic       init;    // restore initial hash values
    } t_eng_ctl;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word init_hash(input logic [2:0] i);
        unique case (i)
            3'd0: init_hash = 32'h6a09e667;
            3'd1: init_hash = 32'hbb67ae85;
            3'd2: init_hash = 32'h3c6ef372;
            3'd3: init_hash = 32'ha54ff53a;
            3'd4: init_hash = 32'h510e527f;
            3'd5: init_hash = 32'h9b05688c;
            3'd6: init_hash = 32'h1f83d9ab;
            default: init_hash = 32'h5be0cd19;
        endcase
    endfunction

    function automatic t_word round_k(input logic [5:0] r);
        t_word k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa704,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        round_k = k[r];
    endfunction

endpackage

// ----- hw/rtl/sha256_if.sv -----
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- hw/rtl/sha256_engine.sv -----
// Round engine: the message schedule is a 16-entry register ring read at four
// fixed offsets from the round number, so one round completes in the cycle in
// which its control pulse is high.
module sha256_engine
    import sha256_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_eng_ctl   i_ctl,
    input  t_word      i_w_in,      // message word for rounds 0..15
    input  logic [2:0] i_hsel,
    output t_word      o_hash
);
    t_word r_hash [8];
    t_word r_v [8];
    t_word r_sched [SchedDepth];
    t_word w_new, t1, t2, w2, w7, w15, w16, e, a, s0, s1;

    // Schedule taps are read from flop storage at fixed tap offsets.
    assign w2  = r_sched[4'(i_ctl.idx - 6'd2)];
    assign w7  = r_sched[4'(i_ctl.idx - 6'd7)];
    assign w15 = r_sched[4'(i_ctl.idx - 6'd15)];
    assign w16 = r_sched[i_ctl.idx[3:0]];
    assign s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    assign s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    assign w_new = (i_ctl.idx < 6'd16) ? i_w_in : s1 + w7 + s0 + w16;
    assign e = r_v[4];
    assign a = r_v[0];
    assign t1 = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & r_v[5]) ^ (~e & r_v[6])) + round_k(i_ctl.idx) + w_new;
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        if (i_ctl.round) begin
            r_sched[i_ctl.idx[3:0]] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            for (int j = 0; j < 8; j++) r_v[j] <= r_hash[j];
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int j = 0; j < 8; j++) r_hash[j] <= init_hash(3'(j));
        end else if (i_ctl.finish) begin
            for (int j = 0; j < 8; j++) r_hash[j] <= r_hash[j] + r_v[j];
        end
    end

    assign o_hash = r_hash[i_hsel];
endmodule

// ----- hw/rtl/sha256_stream_hasher.sv -----
// Byte-stream SHA-256 hasher. One input transaction per byte; bytes are taken
// back to back while the block buffer fills. The 64th byte of a block starts a
// compression that holds off the input: it loads the working variables, runs
// each of rounds 0 to 15 as an address step, four reads through the single
// byte-wide read port of the buffer memory, then the round, runs each of rounds
// 16 to 63 as a setup step and the round, and folds the result into the hash
// words. No new byte is taken until the compression is through. The end of
// message item pads in the buffer at one byte per cycle up to the end of the
// block and runs a compression; when more than 55 bytes were buffered, a second
// all-padding block costs another pass of padding writes and a second
// compression. Then it offers eight digest transactions, word 0 first, and
// takes new input once the last one is accepted.
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    sha256_in_if.sink      i_in,
    sha256_out_if.source   o_out
);
`include "sha256_stream_hasher_macros.svh"

    localparam logic [3:0] S_IDLE = 4'd0, S_PAD = 4'd1, S_LEN = 4'd2, S_START = 4'd3,
                           S_RD = 4'd4, S_GATH = 4'd5, S_RND = 4'd6, S_FIN = 4'd7,
                           S_OUT = 4'd8, S_ZERO2 = 4'd9;

    logic [3:0]  r_st;
    logic [63:0] r_cnt;
    logic [5:0]  r_pos;       // padding write position
    logic [6:0]  r_rnd;       // round index
    logic [1:0]  r_bsel;      // byte within the word being gathered
    logic        r_fin;       // block belongs to finishing sequence
    logic        r_last;      // final compression (the one with the length) pending
    logic [2:0]  r_oidx;
    logic [7:0]  r_mem [BufDepth];
    logic [7:0]  r_rd;
    t_word       r_wacc;
    logic        wr_en;
    logic [BufAw-1:0] wr_addr, rd_addr;
    logic [7:0]  wr_data;
    t_eng_ctl    ctl;
    t_word       hash;
    logic        acc;

    assign i_in.ready = (r_st == S_IDLE);
    assign acc = i_in.valid && i_in.ready;

    // Byte buffer memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        r_rd <= r_mem[rd_addr];
    end

    // Address counter for gathering bytes of the current round word.
    logic [1:0] r_rph;
    assign rd_addr = {r_rnd[3:0], r_rph};

    always_comb begin
        wr_en = 1'b0;
        wr_addr = r_pos;
        wr_data = 8'h00;
        if (acc && i_in.has_byte) begin
            wr_en = 1'b1;
            wr_addr = r_cnt[8:3];
            wr_data = i_in.data_byte;
        end else if (r_st == S_PAD) begin
            // The first padding position is the one just past the last message byte.
            wr_en = 1'b1;
            wr_data = (r_pos == r_cnt[8:3]) ? 8'h80 : 8'h00;
        end else if (r_st == S_LEN) begin
            wr_en = 1'b1;
            wr_data = r_cnt[8'(63 - 8 * r_pos[2:0]) -: 8];
        end
    end

    always_comb begin
        ctl = '0;
        ctl.idx = r_rnd[5:0];
        ctl.start = (r_st == S_START);
        ctl.round = (r_st == S_RND);
        ctl.finish = (r_st == S_FIN);
        ctl.init = (r_st == S_OUT) && o_out.ready && (r_oidx == 3'd7);
    end

    sha256_engine u_eng (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ctl),
        .i_w_in (r_wacc),
        .i_hsel (r_oidx),
        .o_hash (hash)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
            r_pos <= '0;
            r_rnd <= '0;
            r_rph <= '0;
            r_bsel <= '0;
            r_fin <= 1'b0;
            r_last <= 1'b0;
            r_oidx <= '0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (acc) begin
                        logic [63:0] c;
                        c = i_in.has_byte ? r_cnt + 64'd8 : r_cnt;
                        r_cnt <= c;
                        r_fin <= i_in.end_of_message;
                        if (i_in.has_byte && r_cnt[8:3] == 6'd63) begin
                            r_st <= S_START;
                        end else if (i_in.end_of_message) begin
                            r_st <= S_PAD;
                            r_pos <= c[8:3];
                        end
                        r_last <= 1'b0;
                    end
                end
                S_PAD: begin
                    // 0x80 goes at the position just past the message, zeros elsewhere.
                    if (r_pos == 6'd63) begin
                        r_st <= S_START; r_last <= 1'b0;
                    end else if (r_pos == 6'd55) begin
                        r_st <= S_LEN;
                    end
                    r_pos <= r_pos + 6'd1;
                end
                S_LEN: begin
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd63) begin
                        r_st <= S_START; r_last <= 1'b1;
                    end
                end
                S_START: begin
                    r_rnd <= '0; r_rph <= '0; r_bsel <= '0;
                    r_st <= S_RD;
                end
                S_RD: begin
                    if (r_rnd < 7'd16) begin
                        r_rph <= r_rph + 2'd1;
                        r_st <= S_GATH;
                    end else begin
                        r_st <= S_RND;
                    end
                end
                S_GATH: begin
                    r_wacc <= {r_wacc[23:0], r_rd};
                    r_bsel <= r_bsel + 2'd1;
                    if (r_bsel == 2'd3) r_st <= S_RND;
                    else r_rph <= r_rph + 2'd1;
                end
                S_RND: begin
                    r_rnd <= r_rnd + 7'd1;
                    r_rph <= '0;
                    r_bsel <= '0;
                    r_st <= (r_rnd == 7'd63) ? S_FIN : S_RD;
                end
                S_FIN: begin
                    if (!r_fin) r_st <= S_IDLE;
                    else if (r_last) begin
                        r_st <= S_OUT; r_oidx <= '0;
                    end else if (r_pos == 6'd0 && r_cnt[8:3] > 6'd55) begin
                        r_st <= S_ZERO2;
                    end else begin
                        r_st <= S_PAD;
                        r_pos <= r_cnt[8:3];
                    end
                end
                S_ZERO2: begin
                    r_st <= S_PAD;
                    r_pos <= '0;
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_st <= S_IDLE; r_cnt <= '0; r_fin <= 1'b0;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid = (r_st == S_OUT);
    assign o_out.digest_word = hash;
    assign o_out.word_index = r_oidx;
    assign o_out.last_word = (r_oidx == 3'd7);

    `ASSERT_IMPL(a_out_only_out, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    `ASSERT_NEXT(a_last_idle, i_clk, i_rst_n,
        o_out.valid && o_out.ready && o_out.last_word, i_in.ready)
    `ASSERT_IMPL(a_round_range, i_clk, i_rst_n, r_st == S_RND, r_rnd < 7'd64)
endmodule
